// ===== hw/rtl/tnrx_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the option reply table for the Telnet receive responder.
// No dependencies.
package tnrx_pkg;

   localparam logic [7:0] IAC_BYTE = 8'hFF;
   localparam logic [7:0] CMD_WILL = 8'hFB;
   localparam logic [7:0] CMD_WONT = 8'hFC;
   localparam logic [7:0] CMD_DO   = 8'hFD;
   localparam logic [7:0] CMD_DONT = 8'hFE;
   localparam logic [7:0] OPT_SGA  = 8'h03;
   localparam logic [7:0] OPT_ECHO = 8'h01;
   localparam logic [7:0] NO_REPLY = 8'h00;
   localparam logic [7:0] NUL_BYTE = 8'h00;

   localparam logic DEST_QUEUE  = 1'b0;
   localparam logic DEST_CLIENT = 1'b1;

   // Results of one input word: nothing, one byte to the queue, or a
   // three-word reply (IAC, lead, opt) to the client.
   typedef struct packed {
      logic       emit;
      logic       reply;
      logic [7:0] lead;
      logic [7:0] opt;
   } bundle_type;

   function automatic logic [7:0] reply_for(input logic [7:0] c, input logic [7:0] opt);
      logic [7:0] r;
      r = NO_REPLY;
      if (c == CMD_WILL && opt == OPT_SGA) begin
         r = CMD_DO;
      end else if (c == CMD_DO && (opt == OPT_SGA || opt == OPT_ECHO)) begin
         r = CMD_WILL;
      end else if (c == CMD_WONT) begin
         r = CMD_DONT;
      end else if (c == CMD_DONT) begin
         r = CMD_WILL;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/telnet_rx_option_responder.sv =====
`timescale 1ns / 1ps
// Telnet receive-side IAC parser and option responder, top level.
// Depends on tnrx_pkg, tnrx_parser and tnrx_serializer.
//
// Usage:
//   req_* carries one word per received byte (req_cmd = 0) or a disconnect
//   event (req_cmd = 1). rsp_* carries the resulting words: rsp_dest = 0 for
//   the receive queue, 1 for a reply to the client; rsp_last marks the final
//   word caused by one input word.
//   A result word is registered and appears in the cycle after its input is accepted.
//   An option reply sends its three words one at a time from the single result
//   register. A new input is taken in the cycle the last pending result word
//   leaves, so while rsp_stall is low words follow back to back. Inputs that
//   give no result are taken every cycle while the result register is empty.
//   Reset returns the parser to the data phase, clears the NUL and pending
//   command state and empties the result register.
//   While rsp_stall is high the current result word holds, and req_stall
//   stays high as long as a result word is held in the register.
module telnet_rx_option_responder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_cmd,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_dest,
   output logic       rsp_last
);

   tnrx_pkg::bundle_type bundle;
   logic                 can_take;
   logic                 accept;

   assign req_stall = !can_take;
   assign accept    = req_valid && can_take;

   tnrx_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .cmd     (req_cmd),
      .rx_byte (req_rx_byte),
      .bundle  (bundle)
   );

   tnrx_serializer u_serializer (
      .clock        (clock),
      .reset        (reset),
      .load         (accept),
      .bundle       (bundle),
      .can_take     (can_take),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_dest     (rsp_dest),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== hw/rtl/tnrx_parser.sv =====
`timescale 1ns / 1ps
// Telnet IAC parser: phase, pending command and NUL state, one word per cycle while accept is high.
// Depends on tnrx_pkg.
module tnrx_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  cmd,
   input  logic [7:0]            rx_byte,
   output tnrx_pkg::bundle_type  bundle
);

   typedef enum logic [1:0] {
      PH_DATA = 2'd0,
      PH_IAC  = 2'd1,
      PH_CMD  = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] pending_ff, pending_in;
   logic       null_seen_ff, null_seen_in;
   logic [7:0] reply_cmd;

   assign reply_cmd = tnrx_pkg::reply_for(pending_ff, rx_byte);

   always_comb begin
      phase_in     = phase_ff;
      pending_in   = pending_ff;
      null_seen_in = null_seen_ff;
      bundle       = '0;
      bundle.lead  = rx_byte;
      bundle.opt   = rx_byte;
      if (cmd) begin
         phase_in = PH_DATA;
      end else begin
         unique case (phase_ff)
            PH_IAC: begin
               if (rx_byte == tnrx_pkg::IAC_BYTE) begin
                  phase_in    = PH_DATA;
                  bundle.emit = 1'b1;
               end else begin
                  pending_in = rx_byte;
                  phase_in   = PH_CMD;
               end
            end
            PH_CMD: begin
               phase_in = PH_DATA;
               if (reply_cmd != tnrx_pkg::NO_REPLY) begin
                  bundle.emit  = 1'b1;
                  bundle.reply = 1'b1;
                  bundle.lead  = reply_cmd;
               end
            end
            default: begin
               phase_in = PH_DATA;
               if (rx_byte == tnrx_pkg::IAC_BYTE) begin
                  phase_in = PH_IAC;
               end else if (rx_byte != tnrx_pkg::NUL_BYTE || null_seen_ff) begin
                  null_seen_in = 1'b0;
                  bundle.emit  = 1'b1;
               end else begin
                  null_seen_in = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DATA;
         pending_ff   <= '0;
         null_seen_ff <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         pending_ff   <= pending_in;
         null_seen_ff <= null_seen_in;
      end
   end

endmodule

// ===== hw/rtl/tnrx_serializer.sv =====
`timescale 1ns / 1ps
// Result register: holds one bundle and sends its one or three words out.
// Depends on tnrx_pkg.
module tnrx_serializer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  tnrx_pkg::bundle_type  bundle,
   output logic                  can_take,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_dest,
   output logic                  rsp_last
);

   tnrx_pkg::bundle_type hold_ff, hold_in;
   logic [1:0]           idx_ff, idx_in;
   logic                 busy_ff, busy_in;
   logic                 fire;

   assign rsp_valid = busy_ff;
   assign fire      = busy_ff && !rsp_stall;
   assign rsp_last  = !hold_ff.reply || idx_ff == 2'd2;
   assign rsp_dest  = hold_ff.reply ? tnrx_pkg::DEST_CLIENT : tnrx_pkg::DEST_QUEUE;
   assign can_take  = !busy_ff || (fire && rsp_last);

   always_comb begin
      if (!hold_ff.reply) begin
         rsp_out_byte = hold_ff.lead;
      end else begin
         unique case (idx_ff)
            2'd0:    rsp_out_byte = tnrx_pkg::IAC_BYTE;
            2'd1:    rsp_out_byte = hold_ff.lead;
            default: rsp_out_byte = hold_ff.opt;
         endcase
      end
   end

   always_comb begin
      hold_in = hold_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (load && bundle.emit) begin
         hold_in = bundle;
         idx_in  = 2'd0;
         busy_in = 1'b1;
      end else if (fire && rsp_last) begin
         busy_in = 1'b0;
      end else if (fire) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      hold_ff <= hold_in;
   end

endmodule

// ===== dv/tb_telnet_rx_option_responder.sv =====
`timescale 1ns / 1ps
// Testbench for telnet_rx_option_responder: a queued word driver, a checking monitor and a
// predictor of the IAC parser. Depends on tnrx_pkg and the responder RTL.
module tb_telnet_rx_option_responder;

   localparam logic EV_BYTE       = 1'b0;
   localparam logic EV_DISCONNECT = 1'b1;
   localparam int   STIM_WORDS    = 180;
   localparam int   HOLD_START    = 100;
   localparam int   HOLD_CYCLES   = 150;

   typedef enum logic [1:0] {ST_DATA, ST_AFTER_IAC, ST_AFTER_CMD} parse_state_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
   } rx_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       dest;
      logic       last;
   } out_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_cmd = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_dest;
   logic       rsp_last;

   rx_word_type     rx_stream[$];
   out_word_type    predicted_out[$];
   parse_state_type parse_st = ST_DATA;
   logic [7:0]      held_cmd = 8'h00;
   logic            nul_dropped = 1'b0;
   int              mismatches = 0;
   int unsigned     send_gap = 0;
   int unsigned     recv_wait = 0;
   bit              send_steady = 1'b0;
   bit              recv_steady = 1'b0;
   int unsigned     hold_clock = 0;
   int unsigned     hold_left = 0;

   telnet_rx_option_responder u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_dest     (rsp_dest),
      .rsp_last     (rsp_last)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic queue_rx(input logic cmd, input logic [7:0] b);
      rx_stream.push_back('{cmd: cmd, rx_byte: b});
   endtask

   task automatic queue_option(input logic [7:0] c, input logic [7:0] opt);
      queue_rx(EV_BYTE, tnrx_pkg::IAC_BYTE);
      queue_rx(EV_BYTE, c);
      queue_rx(EV_BYTE, opt);
   endtask

   function automatic void add_expected(input logic [7:0] b, input logic d, input logic l);
      predicted_out.push_back('{out_byte: b, dest: d, last: l});
   endfunction

   // Parser model: updates the tracked state and queues the words one input causes.
   function automatic void parse_rx_word(input rx_word_type w);
      logic [7:0] lead;
      if (w.cmd == EV_DISCONNECT) begin
         parse_st = ST_DATA;
         return;
      end
      case (parse_st)
         ST_AFTER_IAC: begin
            if (w.rx_byte == tnrx_pkg::IAC_BYTE) begin
               parse_st = ST_DATA;
               add_expected(tnrx_pkg::IAC_BYTE, tnrx_pkg::DEST_QUEUE, 1'b1);
            end else begin
               held_cmd = w.rx_byte;
               parse_st = ST_AFTER_CMD;
            end
         end
         ST_AFTER_CMD: begin
            parse_st = ST_DATA;
            lead = tnrx_pkg::NO_REPLY;
            case (held_cmd)
               tnrx_pkg::CMD_WILL: begin
                  if (w.rx_byte == tnrx_pkg::OPT_SGA) lead = tnrx_pkg::CMD_DO;
               end
               tnrx_pkg::CMD_DO: begin
                  if (w.rx_byte == tnrx_pkg::OPT_SGA || w.rx_byte == tnrx_pkg::OPT_ECHO)
                     lead = tnrx_pkg::CMD_WILL;
               end
               tnrx_pkg::CMD_WONT: lead = tnrx_pkg::CMD_DONT;
               tnrx_pkg::CMD_DONT: lead = tnrx_pkg::CMD_WILL;
               default:            lead = tnrx_pkg::NO_REPLY;
            endcase
            if (lead != tnrx_pkg::NO_REPLY) begin
               add_expected(tnrx_pkg::IAC_BYTE, tnrx_pkg::DEST_CLIENT, 1'b0);
               add_expected(lead, tnrx_pkg::DEST_CLIENT, 1'b0);
               add_expected(w.rx_byte, tnrx_pkg::DEST_CLIENT, 1'b1);
            end
         end
         default: begin
            parse_st = ST_DATA;
            if (w.rx_byte == tnrx_pkg::IAC_BYTE) begin
               parse_st = ST_AFTER_IAC;
            end else if (w.rx_byte != tnrx_pkg::NUL_BYTE || nul_dropped) begin
               nul_dropped = 1'b0;
               add_expected(w.rx_byte, tnrx_pkg::DEST_QUEUE, 1'b1);
            end else begin
               nul_dropped = 1'b1;
            end
         end
      endcase
   endfunction

   // Driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_cmd <= EV_BYTE;
         req_rx_byte <= 8'h00;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_rx_word('{cmd: req_cmd, rx_byte: req_rx_byte});
            if ($urandom_range(0, 19) == 0) send_steady = ~send_steady;
            send_gap = send_steady ? 0 : $urandom_range(0, 5);
         end else if (!req_valid && send_gap > 0) begin
            send_gap--;
         end
         if (req_valid && req_stall) begin
            // payload holds while stalled
         end else if (send_gap == 0 && rx_stream.size() > 0) begin
            req_valid <= 1'b1;
            req_cmd <= rx_stream[0].cmd;
            req_rx_byte <= rx_stream[0].rx_byte;
            void'(rx_stream.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off so the block backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_clock <= 0;
         hold_left <= 0;
      end else begin
         hold_clock <= hold_clock + 1;
         if (hold_clock == HOLD_START) begin
            hold_left <= HOLD_CYCLES;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end
      end
   end

   // Monitor
   always @(posedge clock) begin
      out_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_out.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected word: expected none, actual byte %h dest %b last %b",
                        $time, rsp_out_byte, rsp_dest, rsp_last);
            end else begin
               want = predicted_out.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  mismatches++;
                  $display("%0t: out_byte mismatch: expected %h, actual %h",
                           $time, want.out_byte, rsp_out_byte);
               end
               if (rsp_dest !== want.dest) begin
                  mismatches++;
                  $display("%0t: dest mismatch: expected %b, actual %b",
                           $time, want.dest, rsp_dest);
               end
               if (rsp_last !== want.last) begin
                  mismatches++;
                  $display("%0t: last mismatch: expected %b, actual %b",
                           $time, want.last, rsp_last);
               end
            end
            if ($urandom_range(0, 19) == 0) recv_steady = ~recv_steady;
            recv_wait = recv_steady ? 0 : $urandom_range(0, 5);
         end else if (recv_wait > 0) begin
            recv_wait--;
         end
         rsp_stall <= (recv_wait > 0) || (hold_left > 0);
      end
   end

   initial begin
      logic [7:0] c;
      logic [7:0] opt;
      int         n;

      // NUL handling and IAC IAC escape
      queue_rx(EV_BYTE, tnrx_pkg::NUL_BYTE);
      queue_rx(EV_BYTE, tnrx_pkg::NUL_BYTE);
      queue_rx(EV_BYTE, tnrx_pkg::NUL_BYTE);
      queue_rx(EV_BYTE, 8'h41);
      queue_rx(EV_BYTE, tnrx_pkg::NUL_BYTE);
      queue_rx(EV_BYTE, tnrx_pkg::IAC_BYTE);
      queue_rx(EV_BYTE, tnrx_pkg::IAC_BYTE);
      queue_rx(EV_BYTE, tnrx_pkg::NUL_BYTE);
      // option replies for WILL, DO, WONT and DONT
      queue_option(tnrx_pkg::CMD_WILL, tnrx_pkg::OPT_SGA);
      queue_option(tnrx_pkg::CMD_DO, tnrx_pkg::OPT_ECHO);
      queue_option(tnrx_pkg::CMD_WONT, 8'hFF);
      queue_option(tnrx_pkg::CMD_DONT, 8'h00);
      // single-byte command eats the next byte
      queue_option(8'hF1, 8'h41);
      // disconnect in the middle of a sequence
      queue_rx(EV_BYTE, tnrx_pkg::IAC_BYTE);
      queue_rx(EV_DISCONNECT, 8'hFF);
      queue_rx(EV_BYTE, 8'h55);

      while (rx_stream.size() < STIM_WORDS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               case ($urandom_range(0, 4))
                  0: c = tnrx_pkg::CMD_WILL;
                  1: c = tnrx_pkg::CMD_WONT;
                  2: c = tnrx_pkg::CMD_DO;
                  3: c = tnrx_pkg::CMD_DONT;
                  default: c = 8'($urandom_range(0, 255));
               endcase
               case ($urandom_range(0, 3))
                  0: opt = tnrx_pkg::OPT_SGA;
                  1: opt = tnrx_pkg::OPT_ECHO;
                  default: opt = 8'($urandom_range(0, 255));
               endcase
               queue_option(c, opt);
            end
            5: begin
               queue_rx(EV_BYTE, tnrx_pkg::IAC_BYTE);
               queue_rx(EV_BYTE, tnrx_pkg::IAC_BYTE);
            end
            6: begin
               queue_rx(EV_BYTE, tnrx_pkg::NUL_BYTE);
               queue_rx(EV_BYTE, $urandom_range(0, 1) ? tnrx_pkg::NUL_BYTE
                                                      : 8'($urandom_range(0, 255)));
            end
            7: begin
               n = $urandom_range(1, 3);
               repeat (n) queue_rx(EV_BYTE, 8'($urandom_range(0, 255)));
            end
            8: queue_rx(EV_DISCONNECT, 8'($urandom_range(0, 255)));
            default: begin
               queue_rx(EV_BYTE, tnrx_pkg::IAC_BYTE);
               if ($urandom_range(0, 1)) queue_rx(EV_BYTE, 8'($urandom_range(0, 254)));
               queue_rx(EV_DISCONNECT, 8'($urandom_range(0, 255)));
            end
         endcase
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (rx_stream.size() != 0 || req_valid) @(posedge clock);
      while (predicted_out.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_telnet_rx_option_responder: clean");
      end else begin
         $display("tb_telnet_rx_option_responder: errors");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_telnet_rx_option_responder: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/tnrx_pkg.sv
hw/rtl/tnrx_parser.sv
hw/rtl/tnrx_serializer.sv
hw/rtl/telnet_rx_option_responder.sv
dv/tb_telnet_rx_option_responder.sv
